FILE: design/fprc_pkg.sv
// Package for the FIFO page replacement core: shared widths, reset values
// and the control bundle that the top level drives into each frame cell.
// No dependencies.
`default_nettype none

package fprc_pkg;

    // Fixed field widths of the channels.
    localparam int PAGE_W  = 16;
    localparam int SLOT_W  = 3;
    localparam int TOTAL_W = 32;
    localparam int CFG_W   = 4;

    // Frame capacity after reset.
    localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;

    // Saturation limit of the running totals.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic cmp;   // capture the compare result for the new page
        logic wr;    // load the page into this frame
        logic sel;   // this frame is the current victim
        logic en;    // this frame lies inside the active capacity
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: design/fprc_ifs.sv
// Channel interfaces of the FIFO page replacement core: page references in,
// lookup results out, and the capacity write port. Depends on fprc_pkg.
`default_nettype none

interface fprc_page_if;
    logic                        valid;
    logic                        ready;
    logic [fprc_pkg::PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface fprc_result_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [fprc_pkg::SLOT_W-1:0]  frame_slot;
    logic                         evicted_valid;
    logic [fprc_pkg::PAGE_W-1:0]  evicted_page;
    logic [fprc_pkg::TOTAL_W-1:0] hit_total;
    logic [fprc_pkg::TOTAL_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_slot, output evicted_valid,
                    output evicted_page, output hit_total, output fault_total,
                    input ready);
    modport sink   (input valid, input hit, input frame_slot, input evicted_valid,
                    input evicted_page, input hit_total, input fault_total,
                    output ready);
endinterface

interface fprc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [fprc_pkg::CFG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/fprc_cell.sv
// One frame cell of the FIFO page replacement core: holds a page and its
// valid bit, compares against the broadcast page and passes the hit chain on.
// Depends on fprc_pkg.
`default_nettype none

module fprc_cell #(
    parameter int PW = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fprc_pkg::t_cell_ctl i_ctl,
    input  wire logic [PW-1:0]       i_page,
    input  wire logic                i_found,
    output logic                     o_found,
    output logic                     o_first,
    output logic                     o_ev_valid,
    output logic [PW-1:0]            o_ev_page
);
    import fprc_pkg::*;

    logic          r_valid;
    logic          r_match;
    logic [PW-1:0] r_page;

    // Valid bit and compare result are control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= i_ctl.en & r_valid & (r_page == i_page);
            end
            if (i_ctl.wr) begin
                r_valid <= 1'b1;
            end
        end
    end

    // The stored page needs no reset; it is only read while valid.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_page <= i_page;
        end
    end

    // A lower cell that already matched masks this one.
    assign o_found = i_found | r_match;
    assign o_first = r_match & ~i_found;

    // Only the victim cell drives its contents onto the eviction bus.
    assign o_ev_valid = i_ctl.sel & r_valid;
    assign o_ev_page  = (i_ctl.sel & r_valid) ? r_page : '0;

endmodule

`default_nettype wire

FILE: design/fifo_page_replacement_core.sv
// Top level of the FIFO page replacement core: a row of frame cells, the
// FIFO victim pointer, saturating totals and the result register.
// Depends on fprc_pkg, fprc_ifs and fprc_cell.
//
//  Channel   Dir  Payload                                      Accepted when
//  i_page    in   page_number                                  valid && ready
//  o_res     out  hit, frame_slot, evicted_valid/_page, totals valid && ready
//  i_cfg     in   data (frame capacity)                        valid && ready
//
// Each reference is compared in every cell when it is accepted; the lowest
// match is then resolved along the cell chain and the frames are updated.
// A new reference is taken again as soon as the result is in the output
// register; the result register holds while o_res is stalled, and a
// compared reference waits in the cells until the register is free.
// Reset is synchronous, clears valid bits, pointer and totals, and sets the
// capacity to eight frames; both ready outputs stay low while it is held.
`default_nettype none

module fifo_page_replacement_core #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fprc_page_if.sink   i_page,
    fprc_result_if.source o_res,
    fprc_cfg_if.sink    i_cfg
);
    import fprc_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CAP_W = $clog2(FRAMES + 1);
    localparam int PW    = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;

    logic [CFG_W-1:0]   r_cap;
    logic               r_busy;
    logic [PW-1:0]      r_page;
    logic [IDX_W-1:0]   r_victim;
    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_faults;

    logic               r_out_valid;
    logic               r_out_hit;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_ev_valid;
    logic [PAGE_W-1:0]  r_out_ev_page;

    logic [TOTAL_W-1:0] n_hits;
    logic [TOTAL_W-1:0] n_faults;
    logic [IDX_W-1:0]   n_victim;

    logic [CAP_W-1:0]   w_cap;
    logic [IDX_W-1:0]   w_ptr;
    logic               w_accept;
    logic               w_fire;
    logic               w_hit;
    logic [IDX_W-1:0]   w_hit_slot;
    logic               w_ev_valid;
    logic [PW-1:0]      w_ev_page;
    logic [PW-1:0]      w_cell_page;

    logic [FRAMES:0]    w_chain;
    logic [FRAMES-1:0]  w_first;
    logic [FRAMES-1:0]  w_cell_ev_valid;
    logic [PW-1:0]      w_cell_ev_page [FRAMES];
    t_cell_ctl          w_ctl [FRAMES];

    // Handshakes; nothing is taken while reset is held.
    assign i_cfg.ready  = i_rst_n;
    assign i_page.ready = i_rst_n & ~r_busy;
    assign w_accept     = i_page.valid & i_rst_n & ~r_busy;
    assign w_fire       = r_busy & (~r_out_valid | o_res.ready);

    // Effective capacity: zero acts as one, large values clamp to FRAMES.
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CAP_W'(1);
        end else if (int'(r_cap) > FRAMES) begin
            w_cap = CAP_W'(FRAMES);
        end else begin
            w_cap = CAP_W'(r_cap);
        end
    end

    // A pointer left beyond a shrunken capacity restarts at frame 0.
    always_comb begin
        w_ptr = (32'(r_victim) < 32'(w_cap)) ? r_victim : '0;
        if ((32'(w_ptr) + 32'd1) >= 32'(w_cap)) begin
            n_victim = '0;
        end else begin
            n_victim = IDX_W'(32'(w_ptr) + 32'd1);
        end
    end

    // Cells see the incoming page on compare and the held page on load.
    assign w_cell_page = w_accept ? i_page.page_number[PW-1:0] : r_page;

    assign w_chain[0] = 1'b0;
    assign w_hit      = w_chain[FRAMES];

    // The row of frame cells.
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        assign w_ctl[g].cmp = w_accept;
        assign w_ctl[g].en  = (32'(g) < 32'(w_cap));
        assign w_ctl[g].sel = (w_ptr == IDX_W'(g));
        assign w_ctl[g].wr  = w_fire & ~w_hit & (w_ptr == IDX_W'(g));

        fprc_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_page     (w_cell_page),
            .i_found    (w_chain[g]),
            .o_found    (w_chain[g+1]),
            .o_first    (w_first[g]),
            .o_ev_valid (w_cell_ev_valid[g]),
            .o_ev_page  (w_cell_ev_page[g])
        );
    end

    // Encode the one-hot first match and gather the victim's contents.
    always_comb begin
        w_hit_slot = '0;
        w_ev_page  = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (w_first[i]) begin
                w_hit_slot = w_hit_slot | IDX_W'(i);
            end
            w_ev_page = w_ev_page | w_cell_ev_page[i];
        end
        w_ev_valid = |w_cell_ev_valid;
    end

    // Saturating totals.
    assign n_hits   = (r_hits == TOTAL_MAX) ? r_hits : r_hits + 1'b1;
    assign n_faults = (r_faults == TOTAL_MAX) ? r_faults : r_faults + 1'b1;

    // Sequencer, pointer, totals and capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_busy      <= 1'b0;
            r_victim    <= '0;
            r_hits      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                if (w_hit) begin
                    r_hits <= n_hits;
                end else begin
                    r_faults <= n_faults;
                    r_victim <= n_victim;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= i_page.page_number[PW-1:0];
        end
        if (w_fire) begin
            r_out_hit      <= w_hit;
            r_out_slot     <= w_hit ? SLOT_W'(w_hit_slot) : SLOT_W'(w_ptr);
            r_out_ev_valid <= ~w_hit & w_ev_valid;
            r_out_ev_page  <= w_hit ? '0 : PAGE_W'(w_ev_page);
        end
    end

    // Result word.
    assign o_res.valid         = r_out_valid;
    assign o_res.hit           = r_out_hit;
    assign o_res.frame_slot    = r_out_slot;
    assign o_res.evicted_valid = r_out_ev_valid;
    assign o_res.evicted_page  = r_out_ev_page;
    assign o_res.hit_total     = r_hits;
    assign o_res.fault_total   = r_faults;

`ifndef SYNTH
    // At most one cell claims the first match.
    a_first_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first))
        else $error("more than one first-match cell");

    // A new result only appears after a reference was in flight.
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result without a reference in flight");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hit) |-> !r_out_ev_valid)
        else $error("eviction reported on a hit");

    // Exactly one total moves on each resolved reference.
    a_one_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_fire) && r_hits != TOTAL_MAX
         && r_faults != TOTAL_MAX) |-> (r_hits != $past(r_hits)) != (r_faults != $past(r_faults)))
        else $error("totals did not advance exactly once");
`endif

endmodule

`default_nettype wire
